// ===== rtl/imap_pkg.sv =====
// Shared types and constants for the id map lookup table.
package imap_pkg;

	localparam int ID_W      = 32;
	localparam int INDEX_W   = 6;
	localparam int OP_W      = 3;
	localparam int UCOUNT_W  = 7;
	localparam int GCOUNT_W  = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [OP_W-1:0] OP_WR_USER  = 3'd0;
	localparam logic [OP_W-1:0] OP_WR_GROUP = 3'd1;
	localparam logic [OP_W-1:0] OP_MAP_USER = 3'd2;
	localparam logic [OP_W-1:0] OP_MAP_GRP  = 3'd3;
	localparam logic [OP_W-1:0] OP_REV_USER = 3'd4;
	localparam logic [OP_W-1:0] OP_REV_GRP  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_USER_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NOBODY_ID   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NULL_GROUP  = 2'd3;

	localparam logic [ID_W-1:0] ALL_ONES       = '1;
	localparam logic [ID_W-1:0] NOBODY_RESET   = 32'd32767;
	localparam logic [ID_W-1:0] NULL_GRP_RESET = 32'd65535;

	// search token walking down a chain
	typedef struct packed {
		logic            valid;
		logic            rev;
		logic            hit;
		logic [ID_W-1:0] key;
		logic [ID_W-1:0] val;
	} imap_tok_t;

	// entry write broadcast to every cell of a chain
	typedef struct packed {
		logic               en;
		logic [INDEX_W-1:0] index;
		logic [ID_W-1:0]    from_id;
		logic [ID_W-1:0]    to_id;
	} imap_wr_t;

endpackage

// ===== rtl/imap_cell.sv =====
// One table entry plus one stage of the search token path.
module imap_cell
	import imap_pkg::*;
#(
	parameter int CELL_IDX = 0,
	parameter int COUNT_W  = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  imap_wr_t           wr,
	input  logic [COUNT_W-1:0] count,
	input  imap_tok_t          tok_in,
	output imap_tok_t          tok_out
);

	logic [ID_W-1:0] from_q;
	logic [ID_W-1:0] to_q;
	logic            tok_valid_q;
	imap_tok_t       tok_data_q;
	imap_tok_t       tok_next;
	logic            active;
	logic            match;

	always_ff @(posedge clk) begin
		if (wr.en && (32'(wr.index) == 32'(CELL_IDX))) begin
			from_q <= wr.from_id;
			to_q   <= wr.to_id;
		end
	end

	// entry takes part only while it lies below the entry count
	assign active = 32'(count) > 32'(CELL_IDX);
	assign match  = active && !tok_in.hit &&
		(tok_in.key == (tok_in.rev ? to_q : from_q));

	always_comb begin
		tok_next = tok_in;
		if (match) begin
			tok_next.hit = 1'b1;
			tok_next.val = tok_in.rev ? from_q : to_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_data_q <= tok_next;
	end

	always_comb begin
		tok_out       = tok_data_q;
		tok_out.valid = tok_valid_q;
	end

endmodule

// ===== rtl/imap_chain.sv =====
// Row of entry cells; the search token advances one cell per cycle.
module imap_chain
	import imap_pkg::*;
#(
	parameter int DEPTH   = 64,
	parameter int COUNT_W = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  imap_wr_t           wr,
	input  logic [COUNT_W-1:0] count,
	input  imap_tok_t          tok_in,
	output imap_tok_t          tok_out
);

	imap_tok_t tok [DEPTH+1];

	assign tok[0]  = tok_in;
	assign tok_out = tok[DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		imap_cell #(
			.CELL_IDX(i),
			.COUNT_W (COUNT_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.wr     (wr),
			.count  (count),
			.tok_in (tok[i]),
			.tok_out(tok[i+1])
		);
	end

endmodule

// ===== rtl/id_map_lookup_table.sv =====
// Top level of the user/group id map lookup table.
//
// Input channel (in_valid/in_stall) carries op, entry_index, from_id, to_id and
// lookup_id. Write ops load one entry and give no result.
// Lookup ops send a search token down the user chain (USER_MAP_DEPTH cells) or
// the group chain (GROUP_MAP_DEPTH cells), one cell per cycle, first match wins.
// A lookup gives one result on the output channel (out_valid/out_stall) after
// the chain walk, a hold stage and the output register.
// One lookup is in flight at a time; in_stall is high from its acceptance
// until its result enters the output register, so no further input is taken
// before then. Writes and unused ops are taken one per cycle when idle.
// A result held by out_stall does not block the next input transaction.
// Configuration writes (cfg_valid/cfg_ready, always ready) set entry counts and
// miss ids; the user must issue them only while idle; the block does not check.
// Reset clears counts to zero, miss ids to their defaults and all control
// state; table entries are undefined until written.
module id_map_lookup_table
	import imap_pkg::*;
#(
	parameter int USER_MAP_DEPTH  = 64,
	parameter int GROUP_MAP_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [OP_W-1:0]      op,
	input  logic [INDEX_W-1:0]   entry_index,
	input  logic [ID_W-1:0]      from_id,
	input  logic [ID_W-1:0]      to_id,
	input  logic [ID_W-1:0]      lookup_id,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ID_W-1:0]      result_id,
	output logic                 found,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ID_W-1:0]      cfg_data
);

	logic [UCOUNT_W-1:0] user_count_q;
	logic [GCOUNT_W-1:0] group_count_q;
	logic [ID_W-1:0]     nobody_q;
	logic [ID_W-1:0]     null_group_q;

	logic            busy_q;
	logic [OP_W-1:0] op_q;
	logic            hold_valid_q;
	logic [ID_W-1:0] hold_id_q;
	logic            hold_found_q;
	logic            out_valid_q;
	logic [ID_W-1:0] out_id_q;
	logic            out_found_q;

	logic      in_acc;
	logic      is_lookup;
	logic      user_lookup;
	logic      rev_lookup;
	imap_wr_t  user_wr;
	imap_wr_t  group_wr;
	imap_tok_t tok_start;
	imap_tok_t user_tok_in;
	imap_tok_t group_tok_in;
	imap_tok_t user_end;
	imap_tok_t group_end;
	imap_tok_t end_tok;
	logic      done;
	logic      out_load;
	logic [ID_W-1:0] miss_id;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy_q;
	assign in_acc    = in_valid && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_count_q  <= '0;
			group_count_q <= '0;
			nobody_q      <= NOBODY_RESET;
			null_group_q  <= NULL_GRP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_USER_COUNT:  user_count_q  <= cfg_data[UCOUNT_W-1:0];
				REG_GROUP_COUNT: group_count_q <= cfg_data[GCOUNT_W-1:0];
				REG_NOBODY_ID:   nobody_q      <= cfg_data;
				REG_NULL_GROUP:  null_group_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign is_lookup   = op inside {OP_MAP_USER, OP_MAP_GRP, OP_REV_USER, OP_REV_GRP};
	assign user_lookup = (op == OP_MAP_USER) || (op == OP_REV_USER);
	assign rev_lookup  = (op == OP_REV_USER) || (op == OP_REV_GRP);

	always_comb begin
		user_wr.en       = in_acc && (op == OP_WR_USER);
		user_wr.index    = entry_index;
		user_wr.from_id  = from_id;
		user_wr.to_id    = to_id;
		group_wr         = user_wr;
		group_wr.en      = in_acc && (op == OP_WR_GROUP);

		tok_start.valid  = 1'b0;
		tok_start.rev    = rev_lookup;
		tok_start.hit    = 1'b0;
		tok_start.key    = lookup_id;
		tok_start.val    = '0;
		user_tok_in        = tok_start;
		user_tok_in.valid  = in_acc && is_lookup && user_lookup;
		group_tok_in       = tok_start;
		group_tok_in.valid = in_acc && is_lookup && !user_lookup;
	end

	imap_chain #(
		.DEPTH  (USER_MAP_DEPTH),
		.COUNT_W(UCOUNT_W)
	) u_user_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (user_wr),
		.count  (user_count_q),
		.tok_in (user_tok_in),
		.tok_out(user_end)
	);

	imap_chain #(
		.DEPTH  (GROUP_MAP_DEPTH),
		.COUNT_W(GCOUNT_W)
	) u_group_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (group_wr),
		.count  (group_count_q),
		.tok_in (group_tok_in),
		.tok_out(group_end)
	);

	// only one token is ever in flight
	assign end_tok = user_end.valid ? user_end : group_end;
	assign done    = user_end.valid || group_end.valid;

	always_comb begin
		case (op_q)
			OP_MAP_USER: miss_id = nobody_q;
			OP_MAP_GRP:  miss_id = null_group_q;
			default:     miss_id = ALL_ONES;
		endcase
	end

	assign out_load = hold_valid_q && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_acc && is_lookup) begin
				busy_q <= 1'b1;
			end else if (out_load) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				hold_valid_q <= 1'b1;
			end else if (out_load) begin
				hold_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && is_lookup) begin
			op_q <= op;
		end
		if (done) begin
			hold_id_q    <= end_tok.hit ? end_tok.val : miss_id;
			hold_found_q <= end_tok.hit;
		end
		if (out_load) begin
			out_id_q    <= hold_id_q;
			out_found_q <= hold_found_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result_id = out_id_q;
	assign found     = out_found_q;

endmodule
